[hw/rtl/tcp_congestion_window_control_core_macros.svh]
// Assertion macros for the congestion window control core.
// TCWC_ASSERT is checked only outside reset; TCWC_ASSERT_ALWAYS is checked at every edge.
`ifndef TCP_CONGESTION_WINDOW_CONTROL_CORE_MACROS_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_CORE_MACROS_SVH

`define TCWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcwc assertion failed");

`define TCWC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcwc assertion failed");

`endif

[hw/rtl/tcwc_pkg.sv]
// ----------------------------------------------------------------------------
// tcwc_pkg
// Types, codes and helpers shared by the congestion window control core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcwc_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_e;

  localparam logic [1:0] CFG_MSS          = 2'd0;
  localparam logic [1:0] CFG_INIT_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_INIT_THRESH  = 2'd2;

  localparam logic [15:0] MSS_RESET          = 16'd1460;
  localparam logic [31:0] INIT_WINDOW_RESET  = 32'd1460;
  localparam logic [31:0] INIT_THRESH_RESET  = 32'd65535;

  localparam logic PHASE_SLOW_START = 1'b0;
  localparam logic PHASE_CONG_AVOID = 1'b1;

  localparam logic [7:0] DUP_TRIGGER = 8'd3;
  localparam logic [7:0] DUP_MAX     = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] start_sequence;
    logic [15:0] peer_window_in;
    logic [31:0] acked_number;
    logic [15:0] segment_length;
  } tcwc_in_t;

  typedef struct packed {
    logic [31:0] window_now;
    logic [31:0] threshold_now;
    logic        phase;
    logic [31:0] next_sequence;
    logic [7:0]  duplicate_count;
    logic        retransmit;
    logic [31:0] send_budget;
  } tcwc_out_t;

  typedef struct packed {
    logic [15:0] mss;
    logic [31:0] init_window;
    logic [31:0] init_thresh;
  } tcwc_cfg_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic        phase;
    logic [31:0] snd_seq;
    logic [7:0]  dup_cnt;
    logic [15:0] peer_win;
  } tcwc_state_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcwc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tcwc_cfg_regs
// Configuration registers: segment size, initial window and initial threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcwc_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output tcwc_pkg::tcwc_cfg_t    cfg_o
);
  import tcwc_pkg::*;

  tcwc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MSS:         cfg_d.mss         = cfg_wdata_i[15:0];
        CFG_INIT_WINDOW: cfg_d.init_window = cfg_wdata_i;
        CFG_INIT_THRESH: cfg_d.init_thresh = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mss         <= MSS_RESET;
      cfg_q.init_window <= INIT_WINDOW_RESET;
      cfg_q.init_thresh <= INIT_THRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/tcwc_update.sv]
// ----------------------------------------------------------------------------
// tcwc_update
// Next-state and result logic for one event against the connection state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcwc_update (
  input  wire tcwc_pkg::tcwc_state_t state_i,
  input  wire tcwc_pkg::tcwc_in_t    item_i,
  input  wire tcwc_pkg::tcwc_cfg_t   cfg_i,
  output tcwc_pkg::tcwc_state_t      state_o,
  output tcwc_pkg::tcwc_out_t        res_o
);
  import tcwc_pkg::*;

  logic [31:0] mss32;
  logic [31:0] mss3;
  logic [31:0] half_cwnd;
  logic [31:0] cwnd_dbl;
  logic [31:0] cwnd_step;
  logic [7:0]  dup_inc;
  logic        resend;
  logic [31:0] peer32;

  assign mss32     = {16'h0000, cfg_i.mss};
  assign mss3      = sat_add32(mss32, {15'h0000, cfg_i.mss, 1'b0});
  assign half_cwnd = {1'b0, state_i.cwnd[31:1]};
  assign cwnd_dbl  = sat_add32(state_i.cwnd, state_i.cwnd);
  assign cwnd_step = sat_add32(state_i.cwnd, mss32);
  assign dup_inc   = (state_i.dup_cnt == DUP_MAX) ? state_i.dup_cnt : state_i.dup_cnt + 8'd1;

  always_comb begin
    state_o = state_i;
    resend  = 1'b0;
    case (action_e'(item_i.action))
      ACT_OPEN: begin
        state_o.snd_seq  = item_i.start_sequence;
        state_o.peer_win = item_i.peer_window_in;
        state_o.cwnd     = cfg_i.init_window;
        state_o.ssthresh = cfg_i.init_thresh;
        state_o.phase    = PHASE_SLOW_START;
        state_o.dup_cnt  = 8'd0;
      end
      ACT_ACK: begin
        if (item_i.acked_number < state_i.snd_seq) begin
          state_o.dup_cnt = dup_inc;
          if (dup_inc == DUP_TRIGGER) begin
            // Fast retransmit: halve, inflate by three segments, rewind.
            state_o.ssthresh = half_cwnd;
            state_o.cwnd     = sat_add32(half_cwnd, mss3);
            state_o.snd_seq  = item_i.acked_number;
            resend           = 1'b1;
          end else if (dup_inc > DUP_TRIGGER) begin
            state_o.cwnd = cwnd_step;
          end
        end else begin
          state_o.snd_seq = state_i.snd_seq + {16'h0000, item_i.segment_length};
          state_o.dup_cnt = 8'd0;
          if (state_i.phase == PHASE_SLOW_START) begin
            state_o.cwnd = cwnd_dbl;
            if (cwnd_dbl >= state_i.ssthresh) begin
              state_o.phase = PHASE_CONG_AVOID;
            end
          end else begin
            state_o.cwnd = cwnd_step;
          end
        end
      end
      ACT_TIMEOUT: begin
        state_o.ssthresh = half_cwnd;
        state_o.cwnd     = mss32;
        state_o.phase    = PHASE_SLOW_START;
        state_o.dup_cnt  = 8'd0;
        resend           = 1'b1;
      end
      default: state_o = state_i;
    endcase
  end

  assign peer32 = {16'h0000, state_o.peer_win};

  always_comb begin
    res_o.window_now      = state_o.cwnd;
    res_o.threshold_now   = state_o.ssthresh;
    res_o.phase           = state_o.phase;
    res_o.next_sequence   = state_o.snd_seq;
    res_o.duplicate_count = state_o.dup_cnt;
    res_o.retransmit      = resend;
    res_o.send_budget     = (state_o.cwnd < peer32) ? state_o.cwnd : peer32;
  end

endmodule

`default_nettype wire

[hw/rtl/tcwc_out_stage.sv]
// ----------------------------------------------------------------------------
// tcwc_out_stage
// Result register with valid/ready towards the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcwc_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire tcwc_pkg::tcwc_out_t data_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tcwc_pkg::tcwc_out_t      out_data_o
);
  import tcwc_pkg::*;

  logic      valid_q, valid_d;
  tcwc_out_t data_q;

  // The register can take a new item when it is empty or is being drained.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[hw/rtl/tcp_congestion_window_control_core.sv]
// ----------------------------------------------------------------------------
// tcp_congestion_window_control_core
// Sender-side Reno congestion window control, one event per item.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_ready_o    tcwc_in_t  (event)
//  out      output     out_valid_o / out_ready_i  tcwc_out_t (state report)
//  cfg      input      cfg_we_i, no wait          cfg_idx_i, cfg_wdata_i
//
//  One item per cycle sustained while out_ready_i stays high; each item passes
//  the input register, then the result register, from acceptance to result.
//  The connection state register is updated as an item moves into
//  the result register, so back-to-back events see each other's effects.
//  Reset clears the connection state to zero and loads the register defaults.
//  A stalled result holds in the output register while the input register
//  still takes one more item; in_ready_o then drops until the result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_congestion_window_control_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tcwc_pkg::tcwc_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcwc_pkg::tcwc_out_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i
);
  import tcwc_pkg::*;

  tcwc_cfg_t   cfg;
  tcwc_state_t state_q, state_d;
  tcwc_out_t   res;
  tcwc_in_t    in_data_q;
  logic        in_valid_q, in_valid_d;
  logic        out_free;
  logic        advance;

  tcwc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcwc_update u_update (
    .state_i (state_q),
    .item_i  (in_data_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res)
  );

  tcwc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcwc_checker.sv]
// ----------------------------------------------------------------------------
// tcwc_checker
// Port-level assertions for the congestion window control core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_congestion_window_control_core_macros.svh"

module tcwc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire tcwc_pkg::tcwc_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tcwc_pkg::tcwc_out_t out_data_o
);
  import tcwc_pkg::*;

  logic resend_by_dup;
  logic resend_by_timeout;
  logic budget_ok;

  assign resend_by_dup     = out_data_o.duplicate_count == DUP_TRIGGER;
  assign resend_by_timeout = out_data_o.phase == PHASE_SLOW_START &&
                             out_data_o.duplicate_count == 8'd0;
  assign budget_ok         = out_data_o.send_budget <= out_data_o.window_now &&
                             out_data_o.send_budget[31:16] == 16'h0000;

  // A result held back by the consumer keeps its value.
  `TCWC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // An offered item that is not taken stays offered and unchanged.
  `TCWC_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))

  // Nothing is reported in the cycle after reset is seen.
  `TCWC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

  // A resend comes either from the third duplicate or from a timeout.
  `TCWC_ASSERT(a_resend_cause, clk_i, rst_ni, out_valid_o && out_data_o.retransmit |-> resend_by_dup || resend_by_timeout)

  // The budget never exceeds the window and always fits in 16 bits.
  `TCWC_ASSERT(a_budget_bound, clk_i, rst_ni, out_valid_o |-> budget_ok)

endmodule

bind tcp_congestion_window_control_core tcwc_checker u_tcwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
